// File: design/sfb_pkg.sv
// ============================================================================
// sfb_pkg - shared types and constants of the serial frame builder
// Operation codes passed from the front end to the byte sequencer, the
// queue entry type and the fixed header/trailer bytes.
// ============================================================================
`default_nettype none

package sfb_pkg;

    // Fixed framing bytes
    localparam logic [7:0] HEAD_FIRST  = 8'h44;
    localparam logic [7:0] HEAD_SECOND = 8'h57;
    localparam logic [7:0] TAIL_FIRST  = 8'h0D;
    localparam logic [7:0] TAIL_SECOND = 8'h0A;

    // Default queue depth between front end and sequencer
    localparam int FIFO_DEPTH_DEFAULT = 4;

    // Step counter width of the sequencer (at most seven bytes per item)
    localparam int STEP_W = 3;

    // Item kinds on the input tuser
    localparam logic KIND_START   = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    // Work classes handed to the sequencer
    typedef enum logic [2:0] {
        OP_START,          // header, length, command
        OP_START_CLOSE,    // as above, then check and trailer
        OP_PAYLOAD,        // one payload byte
        OP_PAYLOAD_CLOSE,  // payload byte, then check and trailer
        OP_ERROR           // payload byte outside a frame
    } op_t;

    // One queue entry
    typedef struct packed {
        op_t        op;
        logic [7:0] data_a;  // length (start) or payload byte
        logic [7:0] data_b;  // command (start)
        logic [7:0] check;   // check byte for closing ops
    } entry_t;

    // Index of the final step for each op
    function automatic logic [STEP_W-1:0] last_step(input op_t op);
        logic [STEP_W-1:0] res;
        case (op)
            OP_START:         res = STEP_W'(3);
            OP_START_CLOSE:   res = STEP_W'(6);
            OP_PAYLOAD:       res = STEP_W'(0);
            OP_PAYLOAD_CLOSE: res = STEP_W'(3);
            OP_ERROR:         res = STEP_W'(0);
            default:          res = STEP_W'(0);
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

// File: design/serial_frame_builder_sum_check_top.sv
// Throughput: one output byte per cycle while work is queued and m_axis_tready
// does not stall the output; an item makes 1, 4 or 7 output bytes (error/payload,
// start or payload that closes, start of an empty frame). Input transfers continue
// while the queue has room.
// Reset: rst_n asynchronous active low; no frame open, queue and output empty.
// ============================================================================
// serial_frame_builder_sum_check_top - serial frame builder with check byte
// Front end classifies items and keeps frame state, a short queue decouples
// it from the byte sequencer that emits the framed stream.
// ============================================================================
`default_nettype none

module serial_frame_builder_sum_check_top #(
    parameter int FIFO_DEPTH = sfb_pkg::FIFO_DEPTH_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // command[7:0], length[15:8], payload_byte[23:16]
    input  wire logic        s_axis_tuser,   // kind
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // out_byte
    output logic             m_axis_tlast,   // frame_end
    output logic             m_axis_tuser    // error
);

    logic            fifo_full;
    logic            push;
    sfb_pkg::entry_t push_entry;
    logic            pop;
    logic            fifo_valid;
    sfb_pkg::entry_t fifo_head;

    // Item classification and frame state
    sfb_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .fifo_full     (fifo_full),
        .push          (push),
        .push_entry    (push_entry)
    );

    // Decoupling queue
    sfb_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (fifo_full),
        .pop        (pop),
        .valid      (fifo_valid),
        .head       (fifo_head)
    );

    // Byte sequencer and output stage
    sfb_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .fifo_valid    (fifo_valid),
        .fifo_head     (fifo_head),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire

// File: design/sfb_front.sv
// ============================================================================
// sfb_front - input stage of the serial frame builder
// Accepts input transfers, tracks the open frame, byte count and running
// sum, and classifies each item into one queue entry.
// ============================================================================
`default_nettype none

module sfb_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            s_axis_tvalid,
    output logic                 s_axis_tready,
    input  wire logic [23:0]     s_axis_tdata,   // command[7:0], length[15:8], payload_byte[23:16]
    input  wire logic            s_axis_tuser,   // kind
    input  wire logic            fifo_full,
    output logic                 push,
    output sfb_pkg::entry_t      push_entry
);

    logic       frame_open_reg, frame_open_next;
    logic [7:0] bytes_left_reg, bytes_left_next;
    logic [7:0] running_sum_reg, running_sum_next;

    logic [7:0] command;
    logic [7:0] length;
    logic [7:0] payload_byte;
    logic [7:0] sum_add;
    logic [7:0] left_dec;
    logic       accept;

    assign command      = s_axis_tdata[7:0];
    assign length       = s_axis_tdata[15:8];
    assign payload_byte = s_axis_tdata[23:16];

    assign s_axis_tready = !fifo_full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign push          = accept;

    assign sum_add  = running_sum_reg + payload_byte;
    assign left_dec = bytes_left_reg - 8'd1;

    // Classify item and compute next frame state
    always_comb
    begin
        frame_open_next   = frame_open_reg;
        bytes_left_next   = bytes_left_reg;
        running_sum_next  = running_sum_reg;
        push_entry.op     = sfb_pkg::OP_ERROR;
        push_entry.data_a = 8'h00;
        push_entry.data_b = command;
        push_entry.check  = command;
        if (s_axis_tuser == sfb_pkg::KIND_START)
        begin
            push_entry.data_a = length;
            if (length == 8'h00)
            begin
                // zero length closes at once, check equals the command
                push_entry.op    = sfb_pkg::OP_START_CLOSE;
                frame_open_next  = 1'b0;
                bytes_left_next  = 8'h00;
                running_sum_next = 8'h00;
            end
            else
            begin
                push_entry.op    = sfb_pkg::OP_START;
                frame_open_next  = 1'b1;
                bytes_left_next  = length;
                running_sum_next = command;
            end
        end
        else if (frame_open_reg)
        begin
            push_entry.data_a = payload_byte;
            push_entry.check  = sum_add;
            if (left_dec == 8'h00)
            begin
                push_entry.op    = sfb_pkg::OP_PAYLOAD_CLOSE;
                frame_open_next  = 1'b0;
                bytes_left_next  = 8'h00;
                running_sum_next = 8'h00;
            end
            else
            begin
                push_entry.op    = sfb_pkg::OP_PAYLOAD;
                bytes_left_next  = left_dec;
                running_sum_next = sum_add;
            end
        end
    end

    // Frame state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_open_reg  <= 1'b0;
            bytes_left_reg  <= 8'h00;
            running_sum_reg <= 8'h00;
        end
        else if (accept)
        begin
            frame_open_reg  <= frame_open_next;
            bytes_left_reg  <= bytes_left_next;
            running_sum_reg <= running_sum_next;
        end
    end

`ifndef NO_ASSERTIONS
    // an open frame always still expects at least one payload byte
    a_open_count: assert property (@(posedge clk) disable iff (!rst_n)
        frame_open_reg |-> (bytes_left_reg != 8'h00))
        else $error("open frame with zero bytes left");
`endif

endmodule

`default_nettype wire

// File: design/sfb_fifo.sv
// ============================================================================
// sfb_fifo - short queue between front end and byte sequencer
// Flip-flop queue of classified entries with first-word fall-through read.
// ============================================================================
`default_nettype none

module sfb_fifo #(
    parameter int DEPTH = sfb_pkg::FIFO_DEPTH_DEFAULT
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire sfb_pkg::entry_t  push_entry,
    output logic                  full,
    input  wire logic             pop,
    output logic                  valid,
    output sfb_pkg::entry_t       head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sfb_pkg::entry_t  mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign valid   = (count_reg != '0);
    assign head    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

`ifndef NO_ASSERTIONS
    // the front end never pushes into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");

    // occupancy rises by one on a push without a pop
    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not advance on push");
`endif

endmodule

`default_nettype wire

// File: design/sfb_back.sv
// ============================================================================
// sfb_back - byte sequencer of the serial frame builder
// Takes one queue entry at a time and emits its bytes, one per cycle while the
// output is not stalled, through a registered output stage.
// ============================================================================
`default_nettype none

module sfb_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  fifo_valid,
    input  wire sfb_pkg::entry_t       fifo_head,
    output logic                       pop,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [7:0]                 m_axis_tdata,  // out_byte
    output logic                       m_axis_tlast,  // frame_end
    output logic                       m_axis_tuser   // error
);

    sfb_pkg::entry_t            cur_reg, cur_next;
    logic                       cur_valid_reg, cur_valid_next;
    logic [sfb_pkg::STEP_W-1:0] step_reg, step_next;

    logic       m_valid_reg, m_valid_next;
    logic [7:0] m_data_reg, m_data_next;
    logic       m_last_reg, m_last_next;
    logic       m_err_reg, m_err_next;

    logic       out_free;
    logic       emit;
    logic       is_last;
    logic       done;
    logic       load;
    logic [7:0] sel_byte;
    logic       sel_err;
    logic       sel_end;

    assign out_free = !m_valid_reg || m_axis_tready;
    assign emit     = cur_valid_reg && out_free;
    assign is_last  = (step_reg == sfb_pkg::last_step(cur_reg.op));
    assign done     = emit && is_last;
    assign load     = fifo_valid && (!cur_valid_reg || done);
    assign pop      = load;

    // Byte selection for the current op and step
    always_comb
    begin
        sel_byte = 8'h00;
        sel_err  = 1'b0;
        sel_end  = 1'b0;
        case (cur_reg.op)
            sfb_pkg::OP_START, sfb_pkg::OP_START_CLOSE:
            begin
                case (step_reg)
                    3'd0:    sel_byte = sfb_pkg::HEAD_FIRST;
                    3'd1:    sel_byte = sfb_pkg::HEAD_SECOND;
                    3'd2:    sel_byte = cur_reg.data_a;
                    3'd3:    sel_byte = cur_reg.data_b;
                    3'd4:    sel_byte = cur_reg.check;
                    3'd5:    sel_byte = sfb_pkg::TAIL_FIRST;
                    3'd6:
                    begin
                        sel_byte = sfb_pkg::TAIL_SECOND;
                        sel_end  = 1'b1;
                    end
                    default: sel_byte = 8'h00;
                endcase
            end
            sfb_pkg::OP_PAYLOAD, sfb_pkg::OP_PAYLOAD_CLOSE:
            begin
                case (step_reg)
                    3'd0:    sel_byte = cur_reg.data_a;
                    3'd1:    sel_byte = cur_reg.check;
                    3'd2:    sel_byte = sfb_pkg::TAIL_FIRST;
                    3'd3:
                    begin
                        sel_byte = sfb_pkg::TAIL_SECOND;
                        sel_end  = 1'b1;
                    end
                    default: sel_byte = 8'h00;
                endcase
            end
            sfb_pkg::OP_ERROR:
            begin
                sel_err = 1'b1;
            end
            default:
            begin
                sel_byte = 8'h00;
            end
        endcase
    end

    // Sequencer next state
    always_comb
    begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        step_next      = step_reg;
        if (load)
        begin
            cur_next       = fifo_head;
            cur_valid_next = 1'b1;
            step_next      = '0;
        end
        else if (done)
        begin
            cur_valid_next = 1'b0;
        end
        else if (emit)
        begin
            step_next = step_reg + 1'b1;
        end
    end

    // Output stage next state
    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        m_err_next   = m_err_reg;
        if (emit)
        begin
            m_valid_next = 1'b1;
            m_data_next  = sel_byte;
            m_last_next  = sel_end;
            m_err_next   = sel_err;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            step_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            step_reg      <= step_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
        m_err_reg  <= m_err_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tuser  = m_err_reg;

`ifndef NO_ASSERTIONS
    // the step counter never runs past the final byte of its op
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> (step_reg <= sfb_pkg::last_step(cur_reg.op)))
        else $error("sequencer step out of range");

    // an error result carries a zero byte and never ends a frame
    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_err_reg) |-> (m_data_reg == 8'h00 && !m_last_reg))
        else $error("error result with data or frame end");
`endif

endmodule

`default_nettype wire
